FILE: rtl/aetm_pkg.sv
package aetm_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int GAIN_W      = 32;
  localparam int PROD_W      = MAG_W + GAIN_W;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int DIV_CNT_W   = $clog2(GAIN_W);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_EXPOSURE = CFG_IDX_W'(1);

  localparam logic              AUTO_MODE_RST  = 1'b1;
  localparam logic [GAIN_W-1:0] MANUAL_EXP_RST = GAIN_W'(65536);

  typedef struct packed {
    logic meas_en;
    logic max_clear;
    logic gain_clear;
    logic div_start;
    logic div_step;
    logic div_last;
    logic conv_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic max_zero;
  } status_t;

endpackage

FILE: rtl/aetm_if.sv
interface aetm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [aetm_pkg::SAMPLE_BITS-1:0] lum_red;
  logic signed [aetm_pkg::SAMPLE_BITS-1:0] lum_green;
  logic signed [aetm_pkg::SAMPLE_BITS-1:0] lum_blue;
  logic                                 frame_end;

  modport source (output valid, operation, lum_red, lum_green, lum_blue, frame_end,
                  input ready);
  modport sink (input valid, operation, lum_red, lum_green, lum_blue, frame_end,
                output ready);
endinterface

interface aetm_out_if;
  logic                        valid;
  logic                        ready;
  logic [aetm_pkg::BYTE_W-1:0] red_byte;
  logic [aetm_pkg::BYTE_W-1:0] green_byte;
  logic [aetm_pkg::BYTE_W-1:0] blue_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, input ready);
  modport sink (input valid, red_byte, green_byte, blue_byte, output ready);
endinterface

interface aetm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aetm_pkg::CFG_IDX_W-1:0]  index;
  logic [aetm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/aetm_ctrl.sv
module aetm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  input  logic              frame_end_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  aetm_pkg::status_t status_i,
  output aetm_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [aetm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == aetm_pkg::OP_MEASURE) begin
            cmd_o.meas_en = 1'b1;
            if (frame_end_i) begin
              cmd_o.max_clear = 1'b1;
              if (status_i.max_zero) begin
                cmd_o.gain_clear = 1'b1;
              end else begin
                cmd_o.div_start = 1'b1;
                cnt_d           = '0;
                state_d         = ST_DIV;
              end
            end
          end else begin
            cmd_o.conv_load = 1'b1;
            state_d         = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == aetm_pkg::DIV_CNT_W'(aetm_pkg::GAIN_W - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/aetm_dp.sv
module aetm_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  aetm_pkg::cmd_t                     cmd_i,
  output aetm_pkg::status_t                  status_o,
  input  logic [aetm_pkg::SAMPLE_BITS-1:0]   lum_red_i,
  input  logic [aetm_pkg::SAMPLE_BITS-1:0]   lum_green_i,
  input  logic [aetm_pkg::SAMPLE_BITS-1:0]   lum_blue_i,
  input  logic                               cfg_we_i,
  input  logic [aetm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [aetm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [aetm_pkg::BYTE_W-1:0]        red_byte_o,
  output logic [aetm_pkg::BYTE_W-1:0]        green_byte_o,
  output logic [aetm_pkg::BYTE_W-1:0]        blue_byte_o
);

  localparam int MAG_W  = aetm_pkg::MAG_W;
  localparam int GAIN_W = aetm_pkg::GAIN_W;
  localparam int PROD_W = aetm_pkg::PROD_W;
  localparam int BYTE_W = aetm_pkg::BYTE_W;

  logic              auto_mode_q;
  logic [GAIN_W-1:0] manual_exp_q;
  logic [MAG_W-1:0]  run_max_q;
  logic [GAIN_W-1:0] auto_gain_q;

  logic [MAG_W-1:0]  pos [3];
  logic [MAG_W-1:0]  new_max;
  logic [GAIN_W-1:0] gain;
  logic [PROD_W-1:0] prod_q [3];
  logic [BYTE_W-1:0] byte_d [3];
  logic [BYTE_W-1:0] byte_q [3];

  logic [MAG_W-1:0]  divisor_q;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [GAIN_W-1:0] quo_q, quo_d;
  logic [MAG_W:0]    trial;
  logic              ge;

  function automatic logic [MAG_W-1:0] pos_part(logic [aetm_pkg::SAMPLE_BITS-1:0] s);
    pos_part = s[aetm_pkg::SAMPLE_BITS-1] ? '0 : s[MAG_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] to_byte(logic [PROD_W-1:0] p);
    logic [GAIN_W+BYTE_W-1:0] scaled;
    scaled = {p[GAIN_W-1:0], BYTE_W'(0)} - (GAIN_W + BYTE_W)'(p[GAIN_W-1:0]);
    if (p[PROD_W-1:GAIN_W] != '0) begin
      to_byte = '1;
    end else begin
      to_byte = scaled[GAIN_W+BYTE_W-1:GAIN_W];
    end
  endfunction

  always_comb begin
    pos[0]  = pos_part(lum_red_i);
    pos[1]  = pos_part(lum_green_i);
    pos[2]  = pos_part(lum_blue_i);
    new_max = run_max_q;
    for (int c = 0; c < 3; c++) begin
      if (pos[c] > new_max) begin
        new_max = pos[c];
      end
    end
  end

  assign status_o.max_zero = (new_max == '0);
  assign gain = auto_mode_q ? auto_gain_q : manual_exp_q;

  // Restoring division of 2^32 - 1 by the frame maximum, one quotient bit a step.
  always_comb begin
    trial = {rem_q, 1'b1};
    ge    = trial >= {1'b0, divisor_q};
    rem_d = ge ? MAG_W'(trial - {1'b0, divisor_q}) : trial[MAG_W-1:0];
    quo_d = {quo_q[GAIN_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_mode_q  <= aetm_pkg::AUTO_MODE_RST;
      manual_exp_q <= aetm_pkg::MANUAL_EXP_RST;
      run_max_q    <= '0;
      auto_gain_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == aetm_pkg::CFG_AUTO_MODE) begin
        auto_mode_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_index_i == aetm_pkg::CFG_MANUAL_EXPOSURE) begin
        manual_exp_q <= cfg_data_i[GAIN_W-1:0];
      end
      if (cmd_i.max_clear) begin
        run_max_q <= '0;
      end else if (cmd_i.meas_en) begin
        run_max_q <= new_max;
      end
      if (cmd_i.gain_clear) begin
        auto_gain_q <= '0;
      end else if (cmd_i.div_last) begin
        // Ceiling is floor((2^32 - 1) / m) + 1, saturated when m is one.
        auto_gain_q <= (quo_d == '1) ? quo_d : quo_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      divisor_q <= new_max;
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.conv_load) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(pos[c]) * PROD_W'(gain);
      end
    end
    if (cmd_i.out_load) begin
      for (int c = 0; c < 3; c++) begin
        byte_q[c] <= byte_d[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      byte_d[c] = to_byte(prod_q[c]);
    end
  end

  assign red_byte_o   = byte_q[0];
  assign green_byte_o = byte_q[1];
  assign blue_byte_o  = byte_q[2];

endmodule

FILE: rtl/auto_exposure_tone_mapper.sv
// Max-normalizing tone mapper for a high-dynamic-range RGB stream.
// Each frame is sent twice on in_i. Measure beats (operation 0) raise a running
// maximum of the positive channels; the measure beat with frame_end set latches
// the auto gain, a rounded-up reciprocal of that maximum, and clears the maximum.
// Convert beats (operation 1) scale each channel by the auto gain or by the
// manual exposure register, clamp to one and deliver one byte triple on out_o.
// Registers are to be written on cfg_i only while no item is in flight; the block
// does not enforce this; cfg_i is always ready. A plain measure beat leaves the
// input ready. A frame-end measure beat with a nonzero maximum holds the input off
// while the radix-2 divider forms one gain bit per cycle. A convert beat holds the
// input off in the registered multiplier stage until it loads the output register.
// Reset clears the maximum and the auto gain, selects auto mode and sets the
// manual exposure to one. A stalled receiver holds the result in the output
// register; measure beats are still taken, and a later convert beat waits in the
// multiplier stage until the output register frees up.
module auto_exposure_tone_mapper (
  input logic         clk_i,
  input logic         rst_ni,
  aetm_in_if.sink     in_i,
  aetm_out_if.source  out_o,
  aetm_cfg_if.sink    cfg_i
);

  aetm_pkg::cmd_t    cmd;
  aetm_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  aetm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .frame_end_i (in_i.frame_end),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  aetm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .lum_red_i    (in_i.lum_red),
    .lum_green_i  (in_i.lum_green),
    .lum_blue_i   (in_i.lum_blue),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .red_byte_o   (out_o.red_byte),
    .green_byte_o (out_o.green_byte),
    .blue_byte_o  (out_o.blue_byte)
  );

endmodule

FILE: rtl/aetm_checker.sv
module aetm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        operation_i,
  input logic                        frame_end_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [aetm_pkg::BYTE_W-1:0] red_byte_i,
  input logic [aetm_pkg::BYTE_W-1:0] green_byte_i,
  input logic [aetm_pkg::BYTE_W-1:0] blue_byte_i
);

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(red_byte_i) && $stable(green_byte_i) && $stable(blue_byte_i))
    else $error("result changed while stalled");

  a_convert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && operation_i == aetm_pkg::OP_CONVERT |=> !in_ready_i)
    else $error("input taken during multiply stage");

  a_measure_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && operation_i == aetm_pkg::OP_MEASURE && !frame_end_i |=> in_ready_i)
    else $error("plain measure beat stalled the input");

endmodule

bind auto_exposure_tone_mapper aetm_checker u_aetm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .operation_i  (in_i.operation),
  .frame_end_i  (in_i.frame_end),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .red_byte_i   (out_o.red_byte),
  .green_byte_i (out_o.green_byte),
  .blue_byte_i  (out_o.blue_byte)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps

typedef logic signed [aetm_pkg::SAMPLE_BITS-1:0] lum_t;

typedef struct packed {
  lum_t red;
  lum_t green;
  lum_t blue;
} hdr_pixel_t;

typedef struct packed {
  logic [aetm_pkg::BYTE_W-1:0] red;
  logic [aetm_pkg::BYTE_W-1:0] green;
  logic [aetm_pkg::BYTE_W-1:0] blue;
} rgb8_t;

class tone_scoreboard;
  logic                         auto_sel;
  logic [aetm_pkg::GAIN_W-1:0]  manual_gain;
  logic [aetm_pkg::GAIN_W-1:0]  auto_gain;
  logic [aetm_pkg::MAG_W-1:0]   peak;
  rgb8_t                        pending_px[$];
  int                           errors;
  int                           pixels_checked;
  int                           frames_latched;

  function new();
    auto_sel       = aetm_pkg::AUTO_MODE_RST;
    manual_gain    = aetm_pkg::MANUAL_EXP_RST;
    auto_gain      = '0;
    peak           = '0;
    errors         = 0;
    pixels_checked = 0;
    frames_latched = 0;
  endfunction

  function void apply_reg(logic [aetm_pkg::CFG_IDX_W-1:0] idx,
                          logic [aetm_pkg::CFG_DATA_W-1:0] data);
    if (idx == aetm_pkg::CFG_AUTO_MODE) begin
      auto_sel = data[0];
    end else if (idx == aetm_pkg::CFG_MANUAL_EXPOSURE) begin
      manual_gain = data[aetm_pkg::GAIN_W-1:0];
    end
  endfunction

  function logic [aetm_pkg::MAG_W-1:0] magnitude(lum_t s);
    return s[aetm_pkg::SAMPLE_BITS-1] ? '0 : s[aetm_pkg::MAG_W-1:0];
  endfunction

  function logic [aetm_pkg::BYTE_W-1:0] expose(lum_t s, logic [aetm_pkg::GAIN_W-1:0] g);
    logic [63:0] prod;
    logic [63:0] scaled;
    prod = 64'(magnitude(s)) * 64'(g);
    if (prod == 64'd0) return '0;
    if (prod >= 64'h1_0000_0000) return '1;
    scaled = prod * 64'd255;
    return scaled[39:32];
  endfunction

  function void note_beat(hdr_pixel_t px, logic op, logic fe);
    lum_t                        ch[3];
    logic [aetm_pkg::GAIN_W-1:0] g;
    logic [63:0]                 q;
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;
    if (op == aetm_pkg::OP_MEASURE) begin
      foreach (ch[i]) begin
        if (magnitude(ch[i]) > peak) peak = magnitude(ch[i]);
      end
      if (fe) begin
        if (peak == '0) begin
          auto_gain = '0;
        end else begin
          q = (64'h1_0000_0000 + 64'(peak) - 64'd1) / 64'(peak);
          auto_gain = (q > 64'hFFFF_FFFF) ? '1 : q[aetm_pkg::GAIN_W-1:0];
        end
        peak = '0;
        frames_latched++;
      end
    end else begin
      g = auto_sel ? auto_gain : manual_gain;
      pending_px.push_back('{red: expose(px.red, g), green: expose(px.green, g),
                             blue: expose(px.blue, g)});
    end
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("tb: %s", msg);
  endfunction

  function void check_result(rgb8_t got);
    rgb8_t want;
    if (pending_px.size() == 0) begin
      flag($sformatf("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue));
      return;
    end
    want = pending_px.pop_front();
    pixels_checked++;
    if (got.red != want.red)
      flag($sformatf("red_byte expected %0d got %0d", want.red, got.red));
    if (got.green != want.green)
      flag($sformatf("green_byte expected %0d got %0d", want.green, got.green));
    if (got.blue != want.blue)
      flag($sformatf("blue_byte expected %0d got %0d", want.blue, got.blue));
  endfunction
endclass

module tb;
  import aetm_pkg::*;

  logic clk;
  logic rst_n;
  bit   steady;
  int   beats_sent;
  int   cfg_writes;
  int   settings_run;

  aetm_in_if  in_bus ();
  aetm_out_if out_bus ();
  aetm_cfg_if cfg_bus ();

  tone_scoreboard sb;

  auto_exposure_tone_mapper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.apply_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        sb.note_beat('{red: in_bus.lum_red, green: in_bus.lum_green, blue: in_bus.lum_blue},
                     in_bus.operation, in_bus.frame_end);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result('{red: out_bus.red_byte, green: out_bus.green_byte,
                          blue: out_bus.blue_byte});
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int hold;
    int stall;
    hold = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (steady) begin
        out_bus.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_bus.ready) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          hold = stall - 1;
        end else begin
          hold = $urandom_range(0, 15);
        end
      end else begin
        out_bus.ready <= 1'b1;
        hold = $urandom_range(0, 15);
      end
    end
  end

  task automatic send_beat(logic op, hdr_pixel_t px, logic fe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.lum_red   <= px.red;
    in_bus.lum_green <= px.green;
    in_bus.lum_blue  <= px.blue;
    in_bus.frame_end <= fe;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // The gain divider may still be busy after the last result, so wait it out.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic lum_t rand_lum(int unsigned span);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 8) return lum_t'($urandom | 32'h8000_0000);
    if (k < 14) return '0;
    if (k < 17) return lum_t'(32'h7FFF_FFFF);
    if (k < 19) return lum_t'(32'h1);
    if (k < 24) return lum_t'($urandom);
    return lum_t'($urandom & (32'h7FFF_FFFF >> (30 - span)));
  endfunction

  task automatic run_frame();
    hdr_pixel_t  px[$];
    hdr_pixel_t  junk;
    int          n;
    int unsigned span;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    span = $urandom_range(0, 30);
    steady = ($urandom_range(0, 5) == 0);
    repeat (n) px.push_back('{red: rand_lum(span), green: rand_lum(span), blue: rand_lum(span)});
    foreach (px[i]) send_beat(OP_MEASURE, px[i], i == n - 1);
    if ($urandom_range(0, 9) != 0) begin
      foreach (px[i]) send_beat(OP_CONVERT, px[i], $urandom_range(0, 9) == 0);
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        junk = '{red: lum_t'($urandom), green: lum_t'($urandom), blue: lum_t'($urandom)};
        send_beat($urandom_range(0, 1) ? OP_CONVERT : OP_MEASURE, junk,
                  $urandom_range(0, 3) == 0);
      end
    end
  endtask

  task automatic configure(int phase);
    logic [CFG_DATA_W-1:0] mode_word;
    logic [CFG_DATA_W-1:0] gain;
    mode_word = CFG_DATA_W'({$urandom, 1'b0});
    case (phase % 8)
      0: begin mode_word[0] = 1'b1; gain = MANUAL_EXP_RST; end
      1: gain = '1;
      2: gain = '0;
      3: gain = 32'd1;
      4: gain = MANUAL_EXP_RST;
      5: begin mode_word[0] = 1'b1; gain = $urandom; end
      6: gain = $urandom;
      default: gain = $urandom_range(1, 32'h0004_0000);
    endcase
    if ($urandom_range(0, 1)) begin
      program_reg(CFG_AUTO_MODE, mode_word);
      program_reg(CFG_MANUAL_EXPOSURE, gain);
    end else begin
      program_reg(CFG_MANUAL_EXPOSURE, gain);
      program_reg(CFG_AUTO_MODE, mode_word);
    end
    settings_run++;
  endtask

  initial begin
    int directed_beats;
    int phase;
    int target;
    sb = new();
    beats_sent   = 0;
    cfg_writes   = 0;
    settings_run = 0;
    steady       = 1'b0;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_MEASURE;
    in_bus.lum_red   <= '0;
    in_bus.lum_green <= '0;
    in_bus.lum_blue  <= '0;
    in_bus.frame_end <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_AUTO_MODE;
    cfg_bus.data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Convert before any frame has been measured: the auto gain is still zero.
    send_beat(OP_CONVERT, '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000}, 1'b0);
    send_beat(OP_MEASURE, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0}, 1'b0);
    send_beat(OP_MEASURE, '{32'shFFFF_FFFF, 32'sh1, 32'sh0001_0000}, 1'b1);
    send_beat(OP_CONVERT, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0}, 1'b0);
    send_beat(OP_CONVERT, '{32'shFFFF_FFFF, 32'sh1, 32'sh0001_0000}, 1'b1);
    send_beat(OP_MEASURE, '{32'sh0, 32'shFFFF_FFFB, 32'sh8000_0000}, 1'b1);
    send_beat(OP_CONVERT, '{32'sh7FFF_FFFF, 32'sh1, 32'sh0001_0000}, 1'b0);
    send_beat(OP_MEASURE, '{32'sh1, 32'sh0, 32'sh0}, 1'b1);
    send_beat(OP_CONVERT, '{32'sh1, 32'sh2, 32'sh7FFF_FFFF}, 1'b0);
    send_beat(OP_MEASURE, '{32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000}, 1'b1);
    send_beat(OP_CONVERT, '{32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000}, 1'b0);
    send_beat(OP_CONVERT, '{32'sh0000_FFFF, 32'sh0001_0001, 32'shFFFF_0000}, 1'b0);
    send_beat(OP_MEASURE, '{32'sh0003_0000, 32'sh0, 32'shFFFF_FFFF}, 1'b0);
    send_beat(OP_MEASURE, '{32'sh0001_2345, 32'sh2, 32'sh3}, 1'b1);
    send_beat(OP_CONVERT, '{32'sh0003_0000, 32'sh0001_2345, 32'sh0001_8000}, 1'b0);
    settle();
    program_reg(CFG_AUTO_MODE, 32'hFFFF_FFFE);
    program_reg(CFG_MANUAL_EXPOSURE, 32'hFFFF_FFFF);
    send_beat(OP_CONVERT, '{32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0);
    send_beat(OP_CONVERT, '{32'shFFFF_FFFF, 32'sh0, 32'sh0001_0000}, 1'b0);
    settle();
    program_reg(CFG_MANUAL_EXPOSURE, 32'h0);
    send_beat(OP_CONVERT, '{32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh1}, 1'b0);
    settle();
    program_reg(CFG_MANUAL_EXPOSURE, 32'h1);
    send_beat(OP_CONVERT, '{32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh100}, 1'b0);
    settle();
    program_reg(CFG_AUTO_MODE, 32'h0000_0003);
    program_reg(CFG_MANUAL_EXPOSURE, MANUAL_EXP_RST);
    send_beat(OP_CONVERT, '{32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000}, 1'b0);

    directed_beats = beats_sent;
    phase = 0;
    while (beats_sent - directed_beats < 1550) begin
      settle();
      configure(phase);
      phase++;
      target = beats_sent + $urandom_range(60, 140);
      while (beats_sent < target) run_frame();
    end
    settle();
    steady = 1'b0;

    $display("tb: %0d input beats, %0d gains latched, %0d pixels checked",
             beats_sent, sb.frames_latched, sb.pixels_checked);
    $display("tb: %0d register writes across %0d exposure settings, %0d mismatches",
             cfg_writes, settings_run, sb.errors);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
